[rtl/core/swrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swrt_pkg;

  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned WIN_REG_W   = 6;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WIN_REG_W-1:0] WIN_RESET   = 6'd32;
  localparam logic [COUNT_W-1:0]   COUNT_LIMIT = 6'd63;

  // register index, taken from paddr[2]
  localparam logic REG_WIN_CFG = 1'b0;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_ACK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_END   = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  typedef struct packed {
    kind_e            kind;
    logic [SEQ_W-1:0] seq_num;
    logic             checksum_ok;
  } in_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   ack_seq;
    logic [SEQ_W-1:0]   deliver_first;
    logic [COUNT_W-1:0] deliver_count;
    logic [SEQ_W-1:0]   connection_index;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] seq;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/swrt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module swrt_queue
  import swrt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  entry_t            entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign entry_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/swrt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module swrt_front
  import swrt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  in_t    in_data_i,
  input  logic   pop_i,
  output logic   entry_valid_o,
  output entry_t entry_o
);

  logic   full;
  logic   keep;
  logic   push;
  entry_t entry;

  // acks and corrupt data never produce a result: they stop here
  always_comb begin
    entry.seq = in_data_i.seq_num;
    entry.op  = OP_DATA;
    keep      = 1'b0;
    case (in_data_i.kind)
      KIND_START: begin
        entry.op = OP_START;
        keep     = 1'b1;
      end
      KIND_END: begin
        entry.op = OP_END;
        keep     = 1'b1;
      end
      KIND_DATA: begin
        entry.op = OP_DATA;
        keep     = in_data_i.checksum_ok;
      end
      KIND_ACK: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full && keep;

  swrt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop_i),
    .valid_o (entry_valid_o),
    .entry_o (entry_o)
  );

endmodule

`default_nettype wire

[rtl/core/swrt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module swrt_back
  import swrt_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WIN_REG_W-1:0] win_cfg_i,
  input  logic                 entry_valid_i,
  input  entry_t               entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_MAX);
  localparam int unsigned SW1    = SLOT_W + 1;
  localparam int unsigned WV_W   = WIN_REG_W + 1;
  localparam logic [SW1-1:0]  WM  = SW1'(WINDOW_MAX);
  localparam logic [WV_W-1:0] WMV = WV_W'(WINDOW_MAX);

  logic                  receiving_q, receiving_d;
  logic [SEQ_W-1:0]      next_exp_q, next_exp_d;
  logic [SLOT_W-1:0]     ne_slot_q, ne_slot_d;
  logic [WINDOW_MAX-1:0] held_q, held_d;
  logic [SEQ_W-1:0]      conn_q, conn_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  fire;
  logic                  has_result;
  logic [WV_W-1:0]       win;
  logic [COUNT_W-1:0]    limit;
  logic [COUNT_W-1:0]    cap;
  logic [SLOT_W-1:0]     base;
  logic [WINDOW_MAX-1:0] rot;
  logic [WINDOW_MAX-1:0] clr;
  logic [COUNT_W-1:0]    tones;
  logic [COUNT_W-1:0]    run;
  logic [SEQ_W-1:0]      offset;
  logic                  in_order;
  logic                  in_win;
  logic [SLOT_W-1:0]     hslot;
  logic [SLOT_W-1:0]     adv_slot;

  assign fire        = entry_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // effective window and run cap
  always_comb begin
    if (win_cfg_i == '0) begin
      win = WV_W'(1);
    end else if ({1'b0, win_cfg_i} > WMV) begin
      win = WMV;
    end else begin
      win = {1'b0, win_cfg_i};
    end
    limit = (win > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : win[COUNT_W-1:0];
    cap   = limit - COUNT_W'(1);
  end

  // held map rotated so bit 0 is the slot just after the expected one
  always_comb begin
    logic [SW1-1:0] bsum;
    logic [SW1-1:0] isum;
    bsum = {1'b0, ne_slot_q} + SW1'(1);
    if (bsum >= WM) begin
      bsum = bsum - WM;
    end
    base = bsum[SLOT_W-1:0];
    for (int k = 0; k < WINDOW_MAX; k++) begin
      isum = {1'b0, base} + SW1'(k);
      if (isum >= WM) begin
        isum = isum - WM;
      end
      rot[k] = held_q[isum[SLOT_W-1:0]];
    end
    // top position is the expected slot itself
    rot[WINDOW_MAX-1] = 1'b0;
    // trailing ones: index of the lowest clear bit
    tones = COUNT_W'(WINDOW_MAX - 1);
    for (int k = WINDOW_MAX - 1; k >= 0; k--) begin
      if (!rot[k]) begin
        tones = COUNT_W'(k);
      end
    end
    run = (tones > cap) ? cap : tones;
  end

  // slots released by an in-order beat, and the slot of a held one
  always_comb begin
    logic [SW1-1:0] d;
    logic [SW1-1:0] hsum;
    logic [SW1-1:0] asum;
    for (int s = 0; s < WINDOW_MAX; s++) begin
      d = SW1'(s) + WM - {1'b0, base};
      if (d >= WM) begin
        d = d - WM;
      end
      clr[s] = (d < SW1'(run));
    end
    clr[ne_slot_q] = 1'b1;

    offset   = entry_i.seq - next_exp_q;
    in_order = (offset == '0);
    in_win   = (offset < SEQ_W'(win));

    hsum = {1'b0, ne_slot_q} + {1'b0, offset[SLOT_W-1:0]};
    if (hsum >= WM) begin
      hsum = hsum - WM;
    end
    hslot = hsum[SLOT_W-1:0];

    asum = {1'b0, ne_slot_q} + SW1'(run) + SW1'(1);
    if (asum >= WM) begin
      asum = asum - WM;
    end
    adv_slot = asum[SLOT_W-1:0];
  end

  always_comb begin
    receiving_d = receiving_q;
    next_exp_d  = next_exp_q;
    ne_slot_d   = ne_slot_q;
    held_d      = held_q;
    conn_d      = conn_q;
    has_result  = 1'b0;
    out_d.ack_seq          = next_exp_q;
    out_d.deliver_first    = '0;
    out_d.deliver_count    = '0;
    out_d.connection_index = conn_q;
    if (fire) begin
      case (entry_i.op)
        OP_START: begin
          if (!receiving_q) begin
            receiving_d   = 1'b1;
            next_exp_d    = '0;
            ne_slot_d     = '0;
            held_d        = '0;
            has_result    = 1'b1;
            out_d.ack_seq = entry_i.seq;
          end
        end
        OP_END: begin
          if (receiving_q) begin
            receiving_d   = 1'b0;
            conn_d        = conn_q + SEQ_W'(1);
            has_result    = 1'b1;
            out_d.ack_seq = entry_i.seq;
          end
        end
        OP_DATA: begin
          if (receiving_q) begin
            has_result = 1'b1;
            if (in_order) begin
              held_d              = held_q & ~clr;
              next_exp_d          = entry_i.seq + SEQ_W'(run) + SEQ_W'(1);
              ne_slot_d           = adv_slot;
              out_d.ack_seq       = next_exp_d;
              out_d.deliver_first = entry_i.seq;
              out_d.deliver_count = run + COUNT_W'(1);
            end else if (in_win) begin
              held_d[hslot] = 1'b1;
            end
          end
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
    if (fire && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      next_exp_q  <= '0;
      ne_slot_q   <= '0;
      held_q      <= '0;
      conn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      receiving_q <= receiving_d;
      next_exp_q  <= next_exp_d;
      ne_slot_q   <= ne_slot_d;
      held_q      <= held_d;
      conn_q      <= conn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      out_q <= out_d;
    end
  end

  a_run_matches_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.deliver_count != '0) |->
      out_q.ack_seq == out_q.deliver_first + SEQ_W'(out_q.deliver_count))
    else $error("released run does not end at the acknowledged number");

  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (entry_i.op == OP_START) && !receiving_q |=>
      receiving_q && (held_q == '0) && (next_exp_q == '0) && (ne_slot_q == '0))
    else $error("start did not open a clean window");

  a_end_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (entry_i.op == OP_END) && receiving_q |=>
      !receiving_q && (conn_q == $past(conn_q) + SEQ_W'(1)))
    else $error("end did not close the connection and bump the count");

endmodule

`default_nettype wire

[rtl/core/sliding_window_receive_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Receive-side tracker for a selective-repeat window. Each input beat is a
// packet event (start, end, data, ack); the block answers with at most one
// result beat carrying the ack number, the in-order run released and the
// connection number. Acks and bad-checksum data are dropped at the front
// with no result. One event is taken per clock unless the queue is full: the
// front classifies into a two-entry queue, and the back updates the window
// state; a result passes the queue register, then the result register. The
// in-order release of held packets (a trailing-ones count over the
// WINDOW_MAX-bit held map, the whole run capped by the window and by 63) is
// combinational. The window register is at byte address 0 of the APB port and
// should only be written while no events are in flight.
module sliding_window_receive_tracker_top
  import swrt_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WIN_REG_W-1:0] window_q, window_d;
  logic                 wr_en;
  logic                 entry_valid;
  entry_t               entry;
  logic                 pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_WIN_CFG);

  always_comb begin
    window_d = window_q;
    if (wr_en) begin
      window_d = pwdata[WIN_REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_WIN_CFG) begin
      prdata = APB_DATA_W'(window_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else begin
      window_q <= window_d;
    end
  end

  swrt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .pop_i         (pop),
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  swrt_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .win_cfg_i     (window_q),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire
